[sv/pom_pkg.sv]
package pom_pkg;
  localparam int PAGE_COUNT = 256;
  localparam int SEGMENT_PAGES = 16;
  localparam logic [7:0] RESERVED_TAG = 8'hFE;

  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_PAIR  = 2'd2;
  localparam logic [1:0] KIND_CLAIM = 2'd3;

  localparam logic [0:0] REG_KERNEL_TOP = 1'd0;
  localparam logic [0:0] REG_RAM_TOP    = 1'd1;

  typedef struct packed {
    logic       load;      // latch item, clear counters
    logic       init_chk;  // evaluate init bounds
    logic       init_wr;   // write map[addr] with init value, advance
    logic       init_fin;  // commit totals
    logic       claim_chk;
    logic       claim_wr;  // write map[addr], adjust count, advance
    logic       rd;        // issue map read at addr
    logic       run_setup; // set addr for base p
    logic       chk_data;  // evaluate read data for data run
    logic       stk_setup; // set addr for stack region
    logic       chk_stack;
    logic       next_base; // advance p by skip
    logic       step_base; // advance p by one
    logic       done_found;
    logic       done_none;
  } pom_cmd_t;

  typedef struct packed {
    logic bad_init;
    logic bad_claim;
    logic claim_last;
    logic init_last;
    logic rd_zero;     // last read entry was free
    logic data_full;   // data run complete
    logic stk_full;
    logic stk_oob;     // stack region runs past map end
    logic data_oob;
    logic p_end;       // base beyond map
    logic pair;
    logic stk_big;
    logic cnt_zero;    // no free page counted yet
  } pom_sts_t;
endpackage

[sv/page_owner_map_allocator_unit.sv]
// Page owner map allocator: map init, first-fit search and claim over a 256-entry owner map.
// Throughput: one transfer at a time; next input taken once the result has been taken.
// Reset: counts clear, registers take 64/640 KB, then a clearing pass marks every page
// reserved with in_stall held high.
module page_owner_map_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_first_page,
  input  logic [4:0]  in_run_length,
  input  logic [4:0]  in_stack_length,
  input  logic [7:0]  in_owner,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [7:0]  out_base_page,
  output logic [8:0]  out_free_count,
  output logic [10:0] out_used_kb,
  output logic        out_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  pom_pkg::pom_cmd_t cmd;
  pom_pkg::pom_sts_t sts;
  logic [10:0] ktop_r, rtop_r;
  logic        busy_r, busy_nxt;
  logic        start, done, found, err, clearing;
  logic [7:0]  base;
  logic [8:0]  freec;
  logic [10:0] used;

  // config registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r <= 11'd64;
      rtop_r <= 11'd640;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        pom_pkg::REG_KERNEL_TOP: ktop_r <= pwdata[10:0];
        pom_pkg::REG_RAM_TOP:    rtop_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[2])
      pom_pkg::REG_KERNEL_TOP: prdata = {21'd0, ktop_r};
      pom_pkg::REG_RAM_TOP:    prdata = {21'd0, rtop_r};
      default:                 prdata = '0;
    endcase
  end

  // one item in flight; output register holds result until taken
  assign in_stall = busy_r || out_valid || clearing;
  assign start = in_valid && !in_stall;
  always_comb begin
    busy_nxt = busy_r;
    if (start) busy_nxt = 1'b1;
    if (done) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (done) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_found      <= found;
      out_base_page  <= found ? base : 8'd0;
      out_free_count <= freec;
      out_used_kb    <= used;
      out_error      <= err;
    end
  end

  pom_ctrl u_ctrl (
    .clk, .rst_n, .start, .kind(in_kind), .sts, .cmd, .done, .clearing,
    .res_found(found), .res_err(err)
  );

  pom_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .kind(in_kind), .first_page(in_first_page), .run_length(in_run_length),
    .stack_length(in_stack_length), .owner(in_owner),
    .kernel_top_kb(ktop_r), .ram_top_kb(rtop_r),
    .res_base(base), .res_free(freec), .res_used(used)
  );
endmodule

[sv/pom_dp.sv]
module pom_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  pom_pkg::pom_cmd_t   cmd,
  output pom_pkg::pom_sts_t   sts,
  input  logic [1:0]          kind,
  input  logic [7:0]          first_page,
  input  logic [4:0]          run_length,
  input  logic [4:0]          stack_length,
  input  logic [7:0]          owner,
  input  logic [10:0]         kernel_top_kb,
  input  logic [10:0]         ram_top_kb,
  output logic [7:0]          res_base,
  output logic [8:0]          res_free,
  output logic [10:0]         res_used
);
  logic [7:0] mem [pom_pkg::PAGE_COUNT];
  logic [7:0] rdata_r;
  logic [7:0] first_r, tag_r;
  logic [4:0] len_r, stk_r;
  logic       pair_r;
  logic [8:0] p_r, addr_r, cnt_r;
  logic [8:0] ktop_r, rtop_r;
  logic [8:0] total_r, free_r;
  logic [8:0] ktop_c, rtop_c;
  logic [9:0] claim_end;
  logic [9:0] stk_start;

  always_comb begin
    logic [9:0] k, r;
    k = 10'(({1'b0, kernel_top_kb} + 12'd3) >> 2);
    r = 10'({1'b0, ram_top_kb} >> 2);
    ktop_c = (k > 10'(pom_pkg::PAGE_COUNT)) ? 9'(pom_pkg::PAGE_COUNT) : k[8:0];
    rtop_c = (r > 10'(pom_pkg::PAGE_COUNT)) ? 9'(pom_pkg::PAGE_COUNT) : r[8:0];
  end

  assign claim_end = {2'b0, first_r} + {5'b0, len_r};
  assign stk_start = {1'b0, p_r} + 10'(pom_pkg::SEGMENT_PAGES) - {5'b0, stk_r};

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata_r <= mem[addr_r[7:0]];
    if (cmd.init_wr)
      mem[addr_r[7:0]] <= (addr_r < ktop_r || addr_r >= rtop_r) ? pom_pkg::RESERVED_TAG : 8'd0;
    if (cmd.claim_wr) mem[addr_r[7:0]] <= tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      free_r  <= '0;
    end else begin
      if (cmd.init_fin) begin
        total_r <= rtop_r - ktop_r;
        free_r  <= rtop_r - ktop_r;
      end
      if (cmd.claim_wr) begin
        if (rdata_r == 8'd0 && tag_r != 8'd0) free_r <= free_r - 9'd1;
        else if (rdata_r != 8'd0 && tag_r == 8'd0) free_r <= free_r + 9'd1;
      end
    end
  end

  // zero tops at reset make the clearing pass write reserved everywhere
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r <= '0;
      rtop_r <= '0;
      addr_r <= '0;
    end else begin
      if (cmd.load) begin
        first_r <= first_page;
        tag_r   <= owner;
        len_r   <= run_length;
        stk_r   <= stack_length;
        pair_r  <= (kind == pom_pkg::KIND_PAIR);
        ktop_r  <= ktop_c;
        rtop_r  <= rtop_c;
        p_r     <= '0;
        cnt_r   <= '0;
        addr_r  <= (kind == pom_pkg::KIND_CLAIM) ? {1'b0, first_page} : 9'd0;
        res_base <= '0;
      end
      if (cmd.init_wr || cmd.claim_wr) addr_r <= addr_r + 9'd1;
      if (cmd.run_setup) begin
        addr_r <= p_r;
        cnt_r  <= '0;
      end
      if (cmd.chk_data && rdata_r == 8'd0) begin
        cnt_r  <= cnt_r + 9'd1;
        addr_r <= addr_r + 9'd1;
      end
      if (cmd.stk_setup) begin
        addr_r <= stk_start[8:0];
        cnt_r  <= '0;
      end
      if (cmd.chk_stack && rdata_r == 8'd0) begin
        cnt_r  <= cnt_r + 9'd1;
        addr_r <= addr_r + 9'd1;
      end
      // skip past the partial run, else step one
      if (cmd.next_base) p_r <= (cnt_r == 9'd0) ? p_r + 9'd1 : p_r + cnt_r;
      if (cmd.step_base) p_r <= p_r + 9'd1;
      if (cmd.done_found) res_base <= p_r[7:0];
    end
  end

  assign sts.bad_init   = ktop_r > rtop_r;
  assign sts.bad_claim  = claim_end > 10'(pom_pkg::PAGE_COUNT);
  assign sts.claim_last = {1'b0, addr_r} + 10'd1 >= claim_end;
  assign sts.init_last  = addr_r == 9'(pom_pkg::PAGE_COUNT - 1);
  assign sts.rd_zero    = rdata_r == 8'd0;
  assign sts.data_full  = cnt_r >= {4'b0, len_r};
  assign sts.stk_full   = cnt_r >= {4'b0, stk_r};
  assign sts.data_oob   = addr_r >= 9'(pom_pkg::PAGE_COUNT);
  assign sts.stk_oob    = stk_start + {5'b0, stk_r} > 10'(pom_pkg::PAGE_COUNT);
  assign sts.p_end      = p_r >= 9'(pom_pkg::PAGE_COUNT);
  assign sts.pair       = pair_r;
  assign sts.stk_big    = {4'b0, stk_r} > 9'(pom_pkg::SEGMENT_PAGES);
  assign sts.cnt_zero   = cnt_r == 9'd0;

  assign res_free = free_r;
  assign res_used = (total_r > free_r) ? {(total_r - free_r), 2'b00} : 11'd0;
endmodule

[sv/pom_ctrl.sv]
module pom_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        kind,
  input  pom_pkg::pom_sts_t sts,
  output pom_pkg::pom_cmd_t cmd,
  output logic              done,
  output logic              clearing,
  output logic              res_found,
  output logic              res_err
);
  localparam logic [3:0] S_IDLE = 4'd0, S_INIT_CHK = 4'd1, S_INIT_WR = 4'd2,
    S_CL_CHK = 4'd3, S_CL_RD = 4'd4, S_CL_WAIT = 4'd5, S_CL_WR = 4'd6,
    S_BASE = 4'd7, S_D_RD = 4'd8, S_D_CHK = 4'd9, S_S_SET = 4'd10,
    S_S_RD = 4'd11, S_S_CHK = 4'd12, S_DONE = 4'd13, S_SRCH0 = 4'd14,
    S_CLEAR = 4'd15;

  logic [3:0] st_r, st_nxt;
  logic       found_r, found_nxt, err_r, err_nxt;

  always_comb begin
    st_nxt = st_r;
    found_nxt = found_r;
    err_nxt = err_r;
    cmd = '0;
    done = 1'b0;
    unique case (st_r)
      // after reset: mark every page reserved
      S_CLEAR: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) st_nxt = S_IDLE;
      end
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        found_nxt = 1'b0;
        err_nxt = 1'b0;
        unique case (kind)
          pom_pkg::KIND_INIT:  st_nxt = S_INIT_CHK;
          pom_pkg::KIND_CLAIM: st_nxt = S_CL_CHK;
          default:             st_nxt = S_SRCH0;
        endcase
      end
      S_INIT_CHK: if (sts.bad_init) begin
        err_nxt = 1'b1;
        st_nxt = S_DONE;
      end else st_nxt = S_INIT_WR;
      S_INIT_WR: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) begin
          cmd.init_fin = 1'b1;
          st_nxt = S_DONE;
        end
      end
      S_CL_CHK: if (sts.bad_claim) begin
        err_nxt = 1'b1;
        st_nxt = S_DONE;
      end else if (sts.claim_last && sts.data_full) st_nxt = S_DONE;
      else st_nxt = S_CL_RD;
      S_CL_RD: begin
        cmd.rd = 1'b1;
        st_nxt = S_CL_WAIT;
      end
      S_CL_WAIT: st_nxt = S_CL_WR;
      S_CL_WR: begin
        cmd.claim_wr = 1'b1;
        st_nxt = sts.claim_last ? S_DONE : S_CL_RD;
      end
      S_SRCH0: st_nxt = (sts.pair && sts.stk_big) ? S_DONE : S_BASE;
      S_BASE: if (sts.p_end) st_nxt = S_DONE;
      else begin
        cmd.run_setup = 1'b1;
        st_nxt = S_D_RD;
      end
      // first read at base doubles as the "base free" test
      S_D_RD: begin
        cmd.rd = 1'b1;
        st_nxt = S_D_CHK;
      end
      // a zero-length run still needs a free base page
      S_D_CHK: begin
        if (sts.data_full && (sts.rd_zero || !sts.cnt_zero)) begin
          if (!sts.pair) begin
            cmd.done_found = 1'b1; found_nxt = 1'b1; st_nxt = S_DONE;
          end else st_nxt = S_S_SET;
        end else if (!sts.data_full && sts.rd_zero && !sts.data_oob) begin
          cmd.chk_data = 1'b1;
          st_nxt = S_D_RD;
        end else begin
          cmd.next_base = 1'b1; st_nxt = S_BASE;
        end
      end
      S_S_SET: begin
        cmd.stk_setup = 1'b1;
        st_nxt = S_S_RD;
      end
      S_S_RD: if (sts.stk_full) begin
        cmd.done_found = 1'b1; found_nxt = 1'b1; st_nxt = S_DONE;
      end else if (sts.stk_oob) begin
        cmd.step_base = 1'b1; st_nxt = S_BASE;
      end else begin
        cmd.rd = 1'b1; st_nxt = S_S_CHK;
      end
      S_S_CHK: if (sts.rd_zero) begin
        cmd.chk_stack = 1'b1; st_nxt = S_S_RD;
      end else begin
        cmd.step_base = 1'b1; st_nxt = S_BASE;
      end
      S_DONE: begin
        done = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      found_r <= 1'b0;
      err_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      found_r <= found_nxt;
      err_r <= err_nxt;
    end
  end

  assign clearing = (st_r == S_CLEAR);
  assign res_found = found_r;
  assign res_err = err_r;
endmodule
